// File: hw/rtl/glyph_atlas_shelf_allocator_defines.svh
// Assertion macros for the glyph atlas shelf allocator.
// Used by the top level; relies on ports named clock and reset.
`ifndef GLYPH_ATLAS_SHELF_ALLOCATOR_DEFINES_SVH
`define GLYPH_ATLAS_SHELF_ALLOCATOR_DEFINES_SVH

// Condition must hold at every clock edge outside reset.
`define GAS_CHECK(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define GAS_CHECK_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/gas_pkg.sv
// Shared types and constants for the glyph atlas shelf allocator.
// No dependencies.
package gas_pkg;

   localparam int SIDE_W       = 12;
   localparam int ROUND_W      = 13;
   localparam int PAGE_INDEX_W = 8;
   localparam int CELL_W       = 9;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_TOO_LARGE = 2'd1,
      STATUS_NO_PAGE   = 2'd2
   } status_type;

   typedef struct packed {
      status_type                status;
      logic [PAGE_INDEX_W-1:0]   page_index;
      logic [CELL_W-1:0]         cell_x;
      logic [CELL_W-1:0]         cell_y;
      logic                      opened_page;
   } result_type;

endpackage

// File: hw/rtl/gas_side_round.sv
// Rounds one glyph side up to a power of two with a lower bound.
// Depends on gas_pkg.
module gas_side_round #(
   parameter int MIN_CELL = 16
) (
   input  logic [gas_pkg::SIDE_W-1:0]  side,
   output logic [gas_pkg::ROUND_W-1:0] rounded
);
   import gas_pkg::*;

   localparam logic [SIDE_W-1:0]  MinSide  = SIDE_W'(MIN_CELL);
   localparam logic [ROUND_W-1:0] MinRound = ROUND_W'(MIN_CELL);

   logic [SIDE_W-1:0] dec;
   logic [SIDE_W-1:0] s1;
   logic [SIDE_W-1:0] s2;
   logic [SIDE_W-1:0] s4;
   logic [SIDE_W-1:0] s8;

   assign dec = side - SIDE_W'(1);
   assign s1  = dec | (dec >> 1);
   assign s2  = s1 | (s1 >> 2);
   assign s4  = s2 | (s2 >> 4);
   assign s8  = s4 | (s4 >> 8);

   assign rounded = (side <= MinSide) ? MinRound : ({1'b0, s8} + ROUND_W'(1));

endmodule

// File: hw/rtl/gas_shelf.sv
// Shelf state and placement decision for one request per cycle.
// Depends on gas_pkg.
module gas_shelf #(
   parameter int PAGE_SIZE = 512,
   parameter int MAX_CELL  = 256,
   parameter int MAX_PAGES = 256
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        commit,
   input  logic [gas_pkg::ROUND_W-1:0] round_w,
   input  logic [gas_pkg::ROUND_W-1:0] round_h,
   output gas_pkg::result_type         result
);
   import gas_pkg::*;

   localparam int PW = $clog2(MAX_PAGES + 1);
   localparam int HW = $clog2(MAX_CELL + 1);
   localparam int CW = $clog2(PAGE_SIZE + 2 * MAX_CELL + 1);

   localparam logic [ROUND_W-1:0] MaxCell  = ROUND_W'(MAX_CELL);
   localparam logic [CW-1:0]      PageSize = CW'(PAGE_SIZE);
   localparam logic [PW-1:0]      MaxPages = PW'(MAX_PAGES);

   logic          have_page_ff, have_page_in;
   logic [PW-1:0] page_ff, page_in;
   logic [HW-1:0] row_ff, row_in;
   logic [CW-1:0] x_ff, x_in;
   logic [CW-1:0] y_ff, y_in;

   logic          too_large;
   logic [HW-1:0] h;
   logic [CW-1:0] wc;
   logic [CW-1:0] hc;
   logic [PW-1:0] pages0, pages1;
   logic          need1, need2, full1, full2, wrap;
   logic [PW-1:0] page1, page2;
   logic [HW-1:0] row1, row2;
   logic [CW-1:0] x1, y1, x2, y2, x3, y3;
   logic          ok;
   logic          opened;
   logic [PW+PAGE_INDEX_W-1:0] page_ext;
   logic [CW+CELL_W-1:0]       x_ext, y_ext;

   always_comb begin
      too_large = (round_w > MaxCell) || (round_h > MaxCell);
      h  = round_h[HW-1:0];
      wc = CW'(round_w[HW-1:0]);
      hc = CW'(h);

      pages0 = have_page_ff ? page_ff + PW'(1) : '0;
      need1  = !have_page_ff || (row_ff != h);
      full1  = pages0 >= MaxPages;
      page1  = need1 ? pages0 : page_ff;
      pages1 = need1 ? pages0 + PW'(1) : pages0;
      row1   = need1 ? h : row_ff;
      x1     = need1 ? '0 : x_ff;
      y1     = need1 ? '0 : y_ff;

      wrap = (x1 + wc) > PageSize;
      x2   = wrap ? '0 : x1;
      y2   = wrap ? y1 + CW'(row1) : y1;

      need2 = (y2 + hc) > PageSize;
      full2 = pages1 >= MaxPages;
      page2 = need2 ? pages1 : page1;
      row2  = need2 ? h : row1;
      x3    = need2 ? '0 : x2;
      y3    = need2 ? '0 : y2;

      opened = need1 || need2;
      ok     = !too_large && !(need1 && full1) && !(need2 && full2);

      page_ext = {{PAGE_INDEX_W{1'b0}}, page2};
      x_ext    = {{CELL_W{1'b0}}, x3};
      y_ext    = {{CELL_W{1'b0}}, y3};

      result = '0;
      if (too_large) begin
         result.status = STATUS_TOO_LARGE;
      end else if (!ok) begin
         result.status = STATUS_NO_PAGE;
      end else begin
         result.status      = STATUS_OK;
         result.page_index  = page_ext[PAGE_INDEX_W-1:0];
         result.cell_x      = x_ext[CELL_W-1:0];
         result.cell_y      = y_ext[CELL_W-1:0];
         result.opened_page = opened;
      end

      have_page_in = have_page_ff;
      page_in      = page_ff;
      row_in       = row_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      if (commit && ok) begin
         have_page_in = 1'b1;
         page_in      = page2;
         row_in       = row2;
         x_in         = x3 + wc;
         y_in         = y3;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_page_ff <= 1'b0;
         page_ff      <= '0;
         row_ff       <= '0;
         x_ff         <= '0;
         y_ff         <= '0;
      end else begin
         have_page_ff <= have_page_in;
         page_ff      <= page_in;
         row_ff       <= row_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
      end
   end

endmodule

// File: hw/rtl/glyph_atlas_shelf_allocator.sv
// Glyph atlas shelf allocator, top level.
// Depends on gas_pkg, gas_side_round, gas_shelf and the assertion macro header.
//
// Usage:
//   Request channel req_* carries glyph_width and glyph_height (12 bits each);
//   a transaction happens when req_valid and req_ready are both high.
//   Response channel rsp_* returns status, page_index, cell_x, cell_y and
//   opened_page, one response per request, in request order.
//   A request is taken into the input register; its placement is then
//   registered in the response register, which drives rsp_valid.
//   Throughput: one request per cycle while rsp_ready stays high; the
//   placement decision is one pass of compare/add logic from the input
//   register through the shelf state into the response register.
//   Rejected requests (too large, page limit reached) return zero fields and
//   leave the shelf state unchanged.
//   Reset (synchronous) clears the shelf state: no page, all positions zero.
//   When a response waits and rsp_ready is low the response register holds;
//   the input register still takes one more request, then req_ready drops until the response
//   is taken.
`include "glyph_atlas_shelf_allocator_defines.svh"

module glyph_atlas_shelf_allocator #(
   parameter int PAGE_SIZE = 512,
   parameter int MIN_CELL  = 16,
   parameter int MAX_CELL  = 256,
   parameter int MAX_PAGES = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [gas_pkg::SIDE_W-1:0]       req_glyph_width,
   input  logic [gas_pkg::SIDE_W-1:0]       req_glyph_height,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [1:0]                       rsp_status,
   output logic [gas_pkg::PAGE_INDEX_W-1:0] rsp_page_index,
   output logic [gas_pkg::CELL_W-1:0]       rsp_cell_x,
   output logic [gas_pkg::CELL_W-1:0]       rsp_cell_y,
   output logic                             rsp_opened_page
);
   import gas_pkg::*;

   logic              in_valid_ff, in_valid_in;
   logic [SIDE_W-1:0] width_ff, width_in;
   logic [SIDE_W-1:0] height_ff, height_in;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_ff, rsp_in;

   logic               advance;
   logic [ROUND_W-1:0] round_w;
   logic [ROUND_W-1:0] round_h;
   result_type         core_result;

   logic               rsp_zero_ok;
   logic               rsp_left_ok;
   logic               in_wait;

   gas_side_round #(.MIN_CELL(MIN_CELL)) u_round_w (
      .side    (width_ff),
      .rounded (round_w)
   );

   gas_side_round #(.MIN_CELL(MIN_CELL)) u_round_h (
      .side    (height_ff),
      .rounded (round_h)
   );

   gas_shelf #(
      .PAGE_SIZE (PAGE_SIZE),
      .MAX_CELL  (MAX_CELL),
      .MAX_PAGES (MAX_PAGES)
   ) u_shelf (
      .clock   (clock),
      .reset   (reset),
      .commit  (advance),
      .round_w (round_w),
      .round_h (round_h),
      .result  (core_result)
   );

   always_comb begin
      advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
      req_ready = !in_valid_ff || advance;

      in_valid_in = in_valid_ff;
      width_in    = width_ff;
      height_in   = height_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         width_in    = req_glyph_width;
         height_in   = req_glyph_height;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_in       = core_result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      width_ff  <= width_in;
      height_ff <= height_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_ff.status;
   assign rsp_page_index  = rsp_ff.page_index;
   assign rsp_cell_x      = rsp_ff.cell_x;
   assign rsp_cell_y      = rsp_ff.cell_y;
   assign rsp_opened_page = rsp_ff.opened_page;

   assign rsp_zero_ok = !rsp_valid_ff || rsp_ff.status == STATUS_OK ||
                        (rsp_ff.page_index == '0 && rsp_ff.cell_x == '0 &&
                         rsp_ff.cell_y == '0 && !rsp_ff.opened_page);
   assign rsp_left_ok = !rsp_valid_ff || !rsp_ff.opened_page || rsp_ff.cell_x == '0;
   assign in_wait     = in_valid_ff && !rsp_valid_ff;

   `GAS_CHECK(a_reject_zero, rsp_zero_ok, "rejected response has nonzero fields")
   `GAS_CHECK(a_open_left, rsp_left_ok, "fresh page cell not at left edge")
   `GAS_CHECK_NEXT(a_move_out, in_wait, rsp_valid_ff, "held request not moved to response")

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for glyph_atlas_shelf_allocator: rounding, rejects, row wrap,
// page turns, random shelf traffic and page-limit exhaustion, checked by an in-bench predictor.
// Depends on gas_pkg and the glyph_atlas_shelf_allocator RTL.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import gas_pkg::*;

   localparam int ATLAS_SIDE = 512;
   localparam int MIN_SIDE   = 16;
   localparam int MAX_SIDE   = 256;
   localparam int PAGE_LIMIT = 256;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [SIDE_W-1:0]       req_glyph_width = '0;
   logic [SIDE_W-1:0]       req_glyph_height = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [1:0]              rsp_status;
   logic [PAGE_INDEX_W-1:0] rsp_page_index;
   logic [CELL_W-1:0]       rsp_cell_x;
   logic [CELL_W-1:0]       rsp_cell_y;
   logic                    rsp_opened_page;

   int sender_idle_pct   = 17;
   int receiver_idle_pct = 54;
   int fail_count        = 0;

   // predicted shelf state
   bit shelf_open = 1'b0;
   int shelf_page = 0;
   int shelf_row  = 0;
   int shelf_x    = 0;
   int shelf_y    = 0;

   result_type expected_placements[$];

   glyph_atlas_shelf_allocator #(
      .PAGE_SIZE (ATLAS_SIDE),
      .MIN_CELL  (MIN_SIDE),
      .MAX_CELL  (MAX_SIDE),
      .MAX_PAGES (PAGE_LIMIT)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_glyph_width  (req_glyph_width),
      .req_glyph_height (req_glyph_height),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_page_index   (rsp_page_index),
      .rsp_cell_x       (rsp_cell_x),
      .rsp_cell_y       (rsp_cell_y),
      .rsp_opened_page  (rsp_opened_page)
   );

   always #10 clock = ~clock;

   initial begin
      #5_000_000;
      $display("tb_top NOT OK");
      $finish;
   end

   function automatic int round_cell_side(input int raw);
      int p;
      p = 1;
      if (raw <= MIN_SIDE) return MIN_SIDE;
      while (p < raw) p = p << 1;
      return p;
   endfunction

   function automatic int pages_in_use();
      return shelf_open ? shelf_page + 1 : 0;
   endfunction

   function automatic result_type place_glyph(input int raw_w, input int raw_h);
      result_type res;
      int w, h, pages, page, row, x, y;
      bit opened;
      res = '0;
      res.status = STATUS_OK;
      opened = 1'b0;
      w = round_cell_side(raw_w);
      h = round_cell_side(raw_h);
      if (w > MAX_SIDE || h > MAX_SIDE) begin
         res.status = STATUS_TOO_LARGE;
         return res;
      end
      pages = pages_in_use();
      page  = shelf_page;
      row   = shelf_row;
      x     = shelf_x;
      y     = shelf_y;
      if (!shelf_open || row != h) begin
         if (pages >= PAGE_LIMIT) begin
            res.status = STATUS_NO_PAGE;
            return res;
         end
         page = pages;
         pages++;
         row = h; x = 0; y = 0;
         opened = 1'b1;
      end
      if (x + w > ATLAS_SIDE) begin
         x = 0;
         y += row;
      end
      if (y + h > ATLAS_SIDE) begin
         if (pages >= PAGE_LIMIT) begin
            res.status = STATUS_NO_PAGE;
            return res;
         end
         page = pages;
         pages++;
         row = h; x = 0; y = 0;
         opened = 1'b1;
      end
      res.page_index  = PAGE_INDEX_W'(page);
      res.cell_x      = CELL_W'(x);
      res.cell_y      = CELL_W'(y);
      res.opened_page = opened;
      shelf_open = 1'b1;
      shelf_page = page;
      shelf_row  = row;
      shelf_x    = x + w;
      shelf_y    = y;
      return res;
   endfunction

   // raw side value that rounds to the given cell side
   function automatic int fit_side(input int side_len);
      if (side_len <= MIN_SIDE) return $urandom_range(0, MIN_SIDE);
      return $urandom_range(side_len / 2 + 1, side_len);
   endfunction

   function automatic int pick_cell_side(input bit favor_short);
      if (favor_short && $urandom_range(99) < 70) return MIN_SIDE << $urandom_range(0, 2);
      if (favor_short) return MIN_SIDE << $urandom_range(3, 4);
      return MIN_SIDE << $urandom_range(0, 4);
   endfunction

   task automatic send_glyph(input int raw_w, input int raw_h);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_glyph_width  <= SIDE_W'(raw_w);
      req_glyph_height <= SIDE_W'(raw_h);
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_placements.insert(expected_placements.size(), place_glyph(raw_w, raw_h));
   endtask

   task automatic drain_placements();
      req_valid <= 1'b0;
      while (expected_placements.size() != 0) @(posedge clock);
   endtask

   task automatic check_placement();
      result_type want;
      if (expected_placements.size() == 0) begin
         $error("response with no request outstanding: status %0d", rsp_status);
         fail_count++;
      end else begin
         want = expected_placements.pop_front();
         if (rsp_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_status);
            fail_count++;
         end
         if (rsp_page_index !== want.page_index) begin
            $error("page_index: expected %0d, got %0d", want.page_index, rsp_page_index);
            fail_count++;
         end
         if (rsp_cell_x !== want.cell_x) begin
            $error("cell_x: expected %0d, got %0d", want.cell_x, rsp_cell_x);
            fail_count++;
         end
         if (rsp_cell_y !== want.cell_y) begin
            $error("cell_y: expected %0d, got %0d", want.cell_y, rsp_cell_y);
            fail_count++;
         end
         if (rsp_opened_page !== want.opened_page) begin
            $error("opened_page: expected %0d, got %0d", want.opened_page, rsp_opened_page);
            fail_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) check_placement();
      rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
   end

   task automatic test_rounding_and_rejects();
      send_glyph(0, 0);
      send_glyph(16, 16);
      send_glyph(17, 1);
      send_glyph(4095, 4095);
      send_glyph(257, 16);
      send_glyph(16, 257);
      send_glyph(256, 0);
      send_glyph(4095, 0);
      send_glyph(0, 4095);
      send_glyph(2048, 2048);
      send_glyph(1, 2);
   endtask

   task automatic test_row_wrap_and_page_turn();
      send_glyph(256, 256);
      send_glyph(256, 256);
      send_glyph(200, 129);
      send_glyph(255, 256);
      send_glyph(1, 256);
      send_glyph(65, 128);
      send_glyph(128, 33);
      send_glyph(3, 64);
      send_glyph(512, 64);
      send_glyph(4095, 2);
      drain_placements();
   endtask

   task automatic run_shelf_traffic(input int count);
      int sent, run_len, run_cell;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(99) < 10) begin
            send_glyph($urandom_range(0, 4095), $urandom_range(0, 4095));
            sent++;
         end else begin
            run_cell = pick_cell_side(1'b1);
            run_len  = $urandom_range(1, 60);
            for (int i = 0; i < run_len && sent < count; i++) begin
               send_glyph(fit_side(pick_cell_side(1'b0)), fit_side(run_cell));
               sent++;
            end
         end
      end
      drain_placements();
   endtask

   task automatic test_random_shelves();
      sender_idle_pct = 17; receiver_idle_pct = 54;
      run_shelf_traffic(500);
      sender_idle_pct = 54; receiver_idle_pct = 17;
      run_shelf_traffic(500);
      sender_idle_pct = 0; receiver_idle_pct = 0;
      run_shelf_traffic(500);
   endtask

   task automatic test_page_limit();
      int alt_h;
      while (pages_in_use() < PAGE_LIMIT) begin
         alt_h = (shelf_row == MIN_SIDE) ? $urandom_range(17, 32) : $urandom_range(0, 16);
         send_glyph(fit_side(pick_cell_side(1'b0)), alt_h);
      end
      // last page fills, then further rows need a page that is not there
      repeat (80) send_glyph(fit_side(MAX_SIDE), fit_side(shelf_row));
      repeat (20) send_glyph(fit_side(pick_cell_side(1'b0)), fit_side(shelf_row * 2));
      repeat (10) send_glyph($urandom_range(0, 4095), $urandom_range(0, 4095));
      drain_placements();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_rounding_and_rejects();
      test_row_wrap_and_page_turn();
      test_random_shelves();
      test_page_limit();
      drain_placements();
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/gas_pkg.sv
hw/rtl/gas_side_round.sv
hw/rtl/gas_shelf.sv
hw/rtl/glyph_atlas_shelf_allocator.sv
tb/tb_top.sv
